>>> sv/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// shared constants, request codes and the result record of the multiset bag
// ----------------------------------------------------------------------------
package mbt_pkg;

    // default number of entries in the bag store
    localparam int BAG_DEPTH_DEF = 64;

    // fixed field widths
    localparam int VAL_W     = 32;
    localparam int REQ_W     = 2;
    localparam int OUT_CNT_W = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // one finished result
    typedef struct packed {
        logic                 success;
        logic [OUT_CNT_W-1:0] match_count;
        logic                 found;
        logic [OUT_CNT_W-1:0] current_size;
        logic                 is_empty;
    } mbt_result_t;

endpackage

>>> sv/multiset_bag_table_unit.sv
// ----------------------------------------------------------------------------
// multiset_bag_table_unit
// unordered multiset of 32-bit values with add, remove, query and clear
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall): req_type and item_value; one
//   transaction per request. req_stall is high while a request is being
//   worked on, so one request is in the block at a time.
//   response channel (rsp_valid / rsp_stall): one transaction per request
//   with success, match_count, found, current_size and is_empty.
// sequencing
//   add and clear: store and count updated on acceptance, no scan; the
//   result then waits in the done state for the output register
//   query: scans the n entries held, bounded by the one read port of the
//   entry store scanning one entry per cycle
//   remove: as query when the value is absent; when it is found, the scan
//   is followed by a read and a write-back of the last entry
//   next request taken once the result has moved to the output register
// reset
//   occupancy count cleared, store contents left undefined; no clear pass
// stall
//   a finished result waits in the output register; the block still takes
//   and works on the next request, and holds that result until the output
//   register frees
// ----------------------------------------------------------------------------
module multiset_bag_table_unit
    import mbt_pkg::*;
#(
    parameter int BAG_DEPTH = BAG_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [REQ_W-1:0]        req_type,
    input  logic signed [VAL_W-1:0] item_value,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    success,
    output logic [OUT_CNT_W-1:0]    match_count,
    output logic                    found,
    output logic [OUT_CNT_W-1:0]    current_size,
    output logic                    is_empty
);

    logic        core_idle;
    logic        req_accept;
    logic        res_valid;
    logic        res_take;
    mbt_result_t core_res;
    mbt_result_t out_reg;
    logic        out_valid_reg, out_valid_next;

    // requests enter only when the sequencer is idle
    assign req_stall  = !core_idle;
    assign req_accept = req_valid && !req_stall;

    mbt_core #(
        .BAG_DEPTH (BAG_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (req_accept),
        .start_type  (req_type),
        .start_value (item_value),
        .idle        (core_idle),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (core_res)
    );

    // output register: free, or being emptied this cycle
    assign res_take = res_valid && (!out_valid_reg || !rsp_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload holds while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= core_res;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign success      = out_reg.success;
    assign match_count  = out_reg.match_count;
    assign found        = out_reg.found;
    assign current_size = out_reg.current_size;
    assign is_empty     = out_reg.is_empty;

    // accepted request keeps the sequencer busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> req_stall)
        else $error("block took a request but did not go busy");

    // a finished result is held until the output register takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(core_res)))
        else $error("finished result lost before the output register took it");

    // presence is only reported on successful queries
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && found) |-> success)
        else $error("found reported without success");

    // failed add or remove carries no match information
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !success) |-> (match_count == '0 && !found))
        else $error("failed request reports match data");

endmodule

>>> sv/mbt_core.sv
// ----------------------------------------------------------------------------
// mbt_core
// entry store, occupancy count and the scan / move sequencer
// ----------------------------------------------------------------------------
module mbt_core
    import mbt_pkg::*;
#(
    parameter int BAG_DEPTH = BAG_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REQ_W-1:0] start_type,
    input  logic [VAL_W-1:0] start_value,
    output logic             idle,
    output logic             res_valid,
    input  logic             res_take,
    output mbt_result_t      res
);

    localparam int CNT_W = $clog2(BAG_DEPTH + 1);
    localparam int IDX_W = (BAG_DEPTH > 1) ? $clog2(BAG_DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_MOVE_RD = 5'b00100,
        ST_MOVE_WR = 5'b01000,
        ST_DONE    = 5'b10000
    } mbt_state_t;

    mbt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [REQ_W-1:0] op_reg, op_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0] match_reg, match_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             ok_reg, ok_next;
    logic [VAL_W-1:0] rd_data_reg;

    logic [VAL_W-1:0] store_mem [BAG_DEPTH];

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] last_cnt;
    logic [CNT_W-1:0] cmp_cnt;
    logic             scan_more;
    logic             cmp_hit;

    assign last_cnt  = count_reg - CNT_W'(1);
    assign cmp_cnt   = issue_reg - CNT_W'(1);
    assign scan_more = issue_reg < count_reg;
    assign cmp_hit   = rd_vld_reg && (rd_data_reg == value_reg);

    // one write port and one registered read port: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        issue_next   = issue_reg;
        rd_vld_next  = 1'b0;
        match_next   = match_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        ok_next      = ok_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];
        wr_data      = start_value;
        rd_addr      = issue_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = start_type;
                    value_next = start_value;
                    issue_next = '0;
                    match_next = '0;
                    hit_next   = 1'b0;
                    ok_next    = 1'b1;
                    case (start_type)
                        REQ_ADD:
                        begin
                            if (count_reg < CNT_W'(BAG_DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                            state_next = ST_DONE;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle, compare the data of the previous one
                if (scan_more)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + CNT_W'(1);
                end
                if (cmp_hit)
                begin
                    match_next = match_reg + CNT_W'(1);
                    if (!hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_cnt[IDX_W-1:0];
                    end
                end
                if (!scan_more && !rd_vld_reg)
                begin
                    if (op_reg == REQ_REMOVE)
                    begin
                        ok_next    = hit_reg;
                        state_next = hit_reg ? ST_MOVE_RD : ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MOVE_RD:
            begin
                rd_addr    = last_cnt[IDX_W-1:0];
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                // last entry overwrites the first match
                wr_en      = 1'b1;
                wr_addr    = hit_idx_reg;
                wr_data    = rd_data_reg;
                count_next = last_cnt;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        value_reg   <= value_next;
        issue_reg   <= issue_next;
        match_reg   <= match_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        ok_reg      <= ok_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.success      = ok_reg;
        res.match_count  = (op_reg == REQ_QUERY) ? OUT_CNT_W'(match_reg) : '0;
        res.found        = (op_reg == REQ_QUERY) && (match_reg != '0);
        res.current_size = OUT_CNT_W'(count_reg);
        res.is_empty     = (count_reg == '0);
    end

endmodule
